// ===== src/hrcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and key table for the HTTP request completeness check.
// No dependencies; used by hrcc_line_parser and http_request_completeness_check_unit.
package hrcc_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int KEY_LEN         = 14;
    localparam int KEY_POS_BITS    = 4;
    localparam int TERM_BITS       = 3;

    localparam logic [TERM_BITS-1:0] TERM_IDLE = 3'd0;
    localparam logic [TERM_BITS-1:0] TERM_CR1  = 3'd1;
    localparam logic [TERM_BITS-1:0] TERM_LF1  = 3'd2;
    localparam logic [TERM_BITS-1:0] TERM_CR2  = 3'd3;
    localparam logic [TERM_BITS-1:0] TERM_DONE = 3'd4;

    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        PH_REQ   = 3'd0,
        PH_KEY   = 3'd1,
        PH_SKIP  = 3'd2,
        PH_VLEAD = 3'd3,
        PH_VDIG  = 3'd4,
        PH_VDONE = 3'd5
    } t_line_phase;

    typedef struct packed {
        logic step;   // header byte to parse
        logic clear;  // last byte of buffer: back to reset state
    } t_parse_ctl;

    // "Content-Length"
    function automatic logic [7:0] key_char(input logic [KEY_POS_BITS-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/hrcc_line_parser.sv =====
`timescale 1ns / 1ps
// Header line parser: key match against Content-Length and decimal value read.
// Depends on hrcc_pkg. Gives the length as it stands after the current byte.
module hrcc_line_parser
    import hrcc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_parse_ctl             i_ctl,
    input  logic [7:0]             i_byte,
    output logic [LENGTH_BITS-1:0] o_len,
    output logic                   o_len_sat
);

    localparam int KPB = KEY_POS_BITS;
    localparam logic [KPB-1:0] KEY_END = KPB'(KEY_LEN);

    t_line_phase            r_phase, n_phase;
    logic [KPB-1:0]         r_key_pos, n_key_pos;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic                   r_ovf, n_ovf;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_sat, n_sat;

    logic                   w_is_lf, w_blank, w_vblank, w_digit_ch, w_key_hit;
    logic [LENGTH_BITS+3:0] w_acc_ext, w_sum;
    logic                   w_sum_ovf;

    assign w_is_lf    = (i_byte == CH_LF);
    assign w_blank    = (i_byte == CH_SP) || (i_byte == CH_HT);
    assign w_vblank   = w_blank || (i_byte == CH_CR) || (i_byte == CH_VT) || (i_byte == CH_FF);
    assign w_digit_ch = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_key_hit  = (r_key_pos < KEY_END) && (i_byte == key_char(r_key_pos));

    // acc * 10 + digit, overflow when anything lands above the value width
    assign w_acc_ext = {4'd0, r_acc};
    assign w_sum     = (w_acc_ext << 3) + (w_acc_ext << 1)
                     + {{LENGTH_BITS{1'b0}}, i_byte[3:0]};
    assign w_sum_ovf = (w_sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_is_lf) begin
            n_phase = PH_KEY;
        end else begin
            unique case (r_phase)
                PH_KEY: begin
                    priority if (i_byte == CH_COLON) begin
                        n_phase = (r_key_pos == KEY_END) ? PH_VLEAD : PH_SKIP;
                    end else if (r_key_pos == '0 && w_blank) begin
                        n_phase = PH_KEY;
                    end else if (r_key_pos == KEY_END && (w_blank || i_byte == CH_CR)) begin
                        n_phase = PH_KEY;
                    end else if (w_key_hit) begin
                        n_phase = PH_KEY;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_VLEAD: begin
                    priority if (w_vblank) begin
                        n_phase = PH_VLEAD;
                    end else if (i_byte == CH_PLUS || i_byte == CH_MINUS || w_digit_ch) begin
                        n_phase = PH_VDIG;
                    end else begin
                        n_phase = PH_VDONE;
                    end
                end
                PH_VDIG: begin
                    n_phase = w_digit_ch ? PH_VDIG : PH_VDONE;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // key position, value and committed length
    always_comb begin
        n_key_pos = r_key_pos;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_ovf     = r_ovf;
        n_len     = r_len;
        n_sat     = r_sat;
        if (w_is_lf) begin
            if (r_phase == PH_VLEAD || r_phase == PH_VDIG || r_phase == PH_VDONE) begin
                if (r_ovf || (r_neg && r_acc != '0)) begin
                    n_len = '1;
                    n_sat = 1'b1;
                end else begin
                    n_len = r_acc;
                    n_sat = 1'b0;
                end
            end
            n_key_pos = '0;
            n_acc     = '0;
            n_neg     = 1'b0;
            n_ovf     = 1'b0;
        end else begin
            if (r_phase == PH_KEY && i_byte != CH_COLON && !(r_key_pos == '0 && w_blank)
                    && w_key_hit) begin
                n_key_pos = r_key_pos + 1'b1;
            end
            if (r_phase == PH_VLEAD && !w_vblank && i_byte == CH_MINUS) begin
                n_neg = 1'b1;
            end
            if ((r_phase == PH_VLEAD || r_phase == PH_VDIG) && w_digit_ch && !r_ovf) begin
                if (w_sum_ovf) begin
                    n_ovf = 1'b1;
                    n_acc = '1;
                end else begin
                    n_acc = w_sum[LENGTH_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_phase   <= PH_REQ;
            r_key_pos <= '0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_ovf     <= 1'b0;
            r_len     <= '0;
            r_sat     <= 1'b0;
        end else if (i_ctl.step) begin
            r_phase   <= n_phase;
            r_key_pos <= n_key_pos;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_ovf     <= n_ovf;
            r_len     <= n_len;
            r_sat     <= n_sat;
        end
    end

    assign o_len     = i_ctl.step ? n_len : r_len;
    assign o_len_sat = i_ctl.step ? n_sat : r_sat;

    as_key_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_pos <= KEY_END)
        else $error("key position beyond key length");
    as_sat_all_ones : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_len == '1))
        else $error("saturated length not all ones");
    as_ovf_all_ones : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_acc == '1))
        else $error("overflowed value not all ones");

endmodule

// ===== src/http_request_completeness_check_unit.sv =====
`timescale 1ns / 1ps
// Top level of the HTTP request completeness check: item registers, terminator
// search, byte counters and result register. Depends on hrcc_pkg, hrcc_line_parser.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+--------------------------------------------
//  in      | i_in_valid | o_in_stall  | i_data_byte, i_end_of_buffer
//  out     | o_out_valid| i_out_stall | o_request_complete, o_terminator_found,
//          |            |             | o_header_bytes, o_declared_length,
//          |            |             | o_body_bytes, o_length_saturated
//
// One item per cycle unless a held result stalls the pipe; a buffer's last item passes
// the input register and then the result register, where its result holds while stalled.
// The input register feeds one pass of parser and counter logic into the result register.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled result holds and stops the input register only when it is also full.
module http_request_completeness_check_unit
    import hrcc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_request_complete,
    output logic        o_terminator_found,
    output logic [31:0] o_header_bytes,
    output logic [31:0] o_declared_length,
    output logic [31:0] o_body_bytes,
    output logic        o_length_saturated
);

    localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    logic                   r_in_valid, r_in_last;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid;
    logic                   r_complete, r_term, r_sat;
    logic [31:0]            r_head_bytes, r_decl, r_body_bytes;

    logic [TERM_BITS-1:0]   r_term_prog, n_term_prog;
    logic                   r_done, n_done;
    logic [31:0]            r_head_cnt, n_head_cnt;
    logic [31:0]            r_body_cnt, n_body_cnt;

    logic                   w_adv, w_go;
    t_parse_ctl             w_ctl;
    logic [LENGTH_BITS-1:0] w_len;
    logic                   w_len_sat;
    logic [CW-1:0]          w_len_ext, w_body_ext;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_go       = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    assign w_ctl.step  = w_go && !r_done;
    assign w_ctl.clear = w_go && r_in_last;

    hrcc_line_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_line_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_byte    (r_in_byte),
        .o_len     (w_len),
        .o_len_sat (w_len_sat)
    );

    // terminator search and counters
    always_comb begin
        n_term_prog = r_term_prog;
        n_done      = r_done;
        n_head_cnt  = r_head_cnt;
        n_body_cnt  = r_body_cnt;
        if (!r_done) begin
            n_head_cnt = (r_head_cnt == MAX32) ? r_head_cnt : r_head_cnt + 32'd1;
            priority if (r_in_byte == CH_CR) begin
                n_term_prog = (r_term_prog == TERM_LF1) ? TERM_CR2 : TERM_CR1;
            end else if (r_in_byte == CH_LF && r_term_prog == TERM_CR1) begin
                n_term_prog = TERM_LF1;
            end else if (r_in_byte == CH_LF && r_term_prog == TERM_CR2) begin
                n_term_prog = TERM_DONE;
            end else begin
                n_term_prog = TERM_IDLE;
            end
            n_done = (n_term_prog == TERM_DONE);
        end else begin
            n_body_cnt = (r_body_cnt == MAX32) ? r_body_cnt : r_body_cnt + 32'd1;
        end
    end

    assign w_len_ext  = CW'(w_len);
    assign w_body_ext = CW'(n_body_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_prog <= TERM_IDLE;
            r_done      <= 1'b0;
            r_head_cnt  <= '0;
            r_body_cnt  <= '0;
        end else if (w_go) begin
            if (r_in_last) begin
                r_term_prog <= TERM_IDLE;
                r_done      <= 1'b0;
                r_head_cnt  <= '0;
                r_body_cnt  <= '0;
            end else begin
                r_term_prog <= n_term_prog;
                r_done      <= n_done;
                r_head_cnt  <= n_head_cnt;
                r_body_cnt  <= n_body_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_go && r_in_last;
        end
        if (w_go && r_in_last) begin
            if (n_done) begin
                r_complete   <= !w_len_sat && (w_body_ext >= w_len_ext);
                r_term       <= 1'b1;
                r_head_bytes <= n_head_cnt;
                r_decl       <= (w_len_ext > CW'(MAX32)) ? MAX32 : w_len_ext[31:0];
                r_body_bytes <= n_body_cnt;
                r_sat        <= w_len_sat;
            end else begin
                r_complete   <= 1'b0;
                r_term       <= 1'b0;
                r_head_bytes <= '0;
                r_decl       <= '0;
                r_body_bytes <= '0;
                r_sat        <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_request_complete = r_complete;
    assign o_terminator_found = r_term;
    assign o_header_bytes     = r_head_bytes;
    assign o_declared_length  = r_decl;
    assign o_body_bytes       = r_body_bytes;
    assign o_length_saturated = r_sat;

    as_done_prog : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_term_prog == TERM_DONE))
        else $error("header done without full terminator");
    as_no_body_before_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> (r_body_cnt == '0))
        else $error("body counted before terminator");
    as_no_term_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_term) |->
            (!r_complete && r_head_bytes == '0 && r_decl == '0 && !r_sat))
        else $error("result fields set without terminator");
    as_sat_incomplete : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat) |-> !r_complete)
        else $error("saturated length reported complete");
    as_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room ahead");

endmodule

// ===== bench/tb_http_request_completeness_check_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for http_request_completeness_check_unit: directed framing cases,
// then random request buffers under several idle and stall mixes, checked by a byte model.
// Depends on hrcc_pkg and the unit under test.
module tb_http_request_completeness_check_unit;
    import hrcc_pkg::*;

    typedef struct packed {
        logic        complete;
        logic        term;
        logic [31:0] hdr;
        logic [31:0] decl;
        logic [31:0] body;
        logic        sat;
    } t_frame_verdict;

    localparam logic [63:0] LEN_LIMIT = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_buffer;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_request_complete;
    logic        o_terminator_found;
    logic [31:0] o_header_bytes;
    logic [31:0] o_declared_length;
    logic [31:0] o_body_bytes;
    logic        o_length_saturated;

    http_request_completeness_check_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_end_of_buffer    (i_end_of_buffer),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_request_complete (o_request_complete),
        .o_terminator_found (o_terminator_found),
        .o_header_bytes     (o_header_bytes),
        .o_declared_length  (o_declared_length),
        .o_body_bytes       (o_body_bytes),
        .o_length_saturated (o_length_saturated)
    );

    // framing model state
    string        key_text = "Content-Length";
    logic [2:0]   term_prog;
    t_line_phase  phase;
    int           key_pos;
    logic [63:0]  val_acc;
    logic         val_neg;
    logic         val_ovf;
    logic [63:0]  len_val;
    logic         len_sat;
    logic [31:0]  head_cnt;
    logic [31:0]  body_cnt;
    logic         hdr_done;

    t_frame_verdict verdict_q[$];
    t_frame_verdict next_verdict;
    logic [7:0]     pkt[$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_len = 0;
    logic holding = 1'b0;
    event hold_go;

    int  err_count = 0;
    int  bytes_sent = 0;
    int  buffers_sent = 0;
    int  results_seen = 0;
    int  gen_len_hint;

    function automatic void clear_framing();
        term_prog = TERM_IDLE;
        phase     = PH_REQ;
        key_pos   = 0;
        val_acc   = '0;
        val_neg   = 1'b0;
        val_ovf   = 1'b0;
        len_val   = '0;
        len_sat   = 1'b0;
        head_cnt  = '0;
        body_cnt  = '0;
        hdr_done  = 1'b0;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_HT);
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == MAX32) ? v : v + 32'd1;
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (!val_ovf) begin
            if (val_acc > (LEN_LIMIT - d) / 64'd10) begin
                val_ovf = 1'b1;
                val_acc = LEN_LIMIT;
            end else begin
                val_acc = val_acc * 64'd10 + d;
            end
        end
    endfunction

    function automatic void parse_header_byte(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (c == CH_LF) begin
            if (phase == PH_VLEAD || phase == PH_VDIG || phase == PH_VDONE) begin
                if (val_ovf || (val_neg && val_acc != 0)) begin
                    len_val = LEN_LIMIT;
                    len_sat = 1'b1;
                end else begin
                    len_val = val_acc;
                    len_sat = 1'b0;
                end
            end
            phase   = PH_KEY;
            key_pos = 0;
            val_acc = '0;
            val_neg = 1'b0;
            val_ovf = 1'b0;
            return;
        end
        case (phase)
            PH_KEY: begin
                if (c == CH_COLON) begin
                    phase = (key_pos == KEY_LEN) ? PH_VLEAD : PH_SKIP;
                end else if (key_pos == 0 && is_blank(c)) begin
                end else if (key_pos == KEY_LEN && (is_blank(c) || c == CH_CR)) begin
                end else if (key_pos < KEY_LEN && c == 8'(key_text[key_pos])) begin
                    key_pos++;
                end else begin
                    phase = PH_SKIP;
                end
            end
            PH_VLEAD: begin
                if (is_blank(c) || c == CH_CR || c == CH_VT || c == CH_FF) begin
                end else if (c == CH_PLUS) begin
                    phase = PH_VDIG;
                end else if (c == CH_MINUS) begin
                    val_neg = 1'b1;
                    phase   = PH_VDIG;
                end else if (is_digit) begin
                    add_digit(c);
                    phase = PH_VDIG;
                end else begin
                    phase = PH_VDONE;
                end
            end
            PH_VDIG: begin
                if (is_digit) begin
                    add_digit(c);
                end else begin
                    phase = PH_VDONE;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void track_terminator(input logic [7:0] c);
        if (c == CH_CR) begin
            term_prog = (term_prog == TERM_LF1) ? TERM_CR2 : TERM_CR1;
        end else if (c == CH_LF && (term_prog == TERM_CR1 || term_prog == TERM_CR2)) begin
            term_prog = term_prog + 3'd1;
        end else begin
            term_prog = TERM_IDLE;
        end
        if (term_prog == TERM_DONE) begin
            hdr_done = 1'b1;
        end
    endfunction

    function automatic logic predict_framing(input logic [7:0] c, input logic eob,
                                             output t_frame_verdict v);
        v = '0;
        if (!hdr_done) begin
            head_cnt = sat_inc(head_cnt);
            parse_header_byte(c);
            track_terminator(c);
        end else begin
            body_cnt = sat_inc(body_cnt);
        end
        if (!eob) begin
            return 1'b0;
        end
        if (hdr_done) begin
            v.complete = !len_sat && (64'(body_cnt) >= len_val);
            v.term     = 1'b1;
            v.hdr      = head_cnt;
            v.decl     = (len_val > 64'(MAX32)) ? MAX32 : len_val[31:0];
            v.body     = body_cnt;
            v.sat      = len_sat;
        end
        clear_framing();
        return 1'b1;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // clock, timeout, stall driver, long hold-off
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= holding || ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        forever begin
            @(hold_go);
            holding <= 1'b1;
            repeat (hold_len) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (predict_framing(i_data_byte, i_end_of_buffer, next_verdict)) begin
                verdict_q.push_back(next_verdict);
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want = verdict_q.pop_front();
                check_field("request_complete", 32'(o_request_complete), 32'(want.complete));
                check_field("terminator_found", 32'(o_terminator_found), 32'(want.term));
                check_field("header_bytes", o_header_bytes, want.hdr);
                check_field("declared_length", o_declared_length, want.decl);
                check_field("body_bytes", o_body_bytes, want.body);
                check_field("length_saturated", 32'(o_length_saturated), 32'(want.sat));
            end
        end
    end

    // stimulus
    task automatic send_byte(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_pkt();
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
        pkt.delete();
        buffers_sent++;
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pkt.push_back(8'(s[i]));
        end
    endtask

    task automatic send_str(input string s);
        put_str(s);
        send_pkt();
    endtask

    task automatic put_text(input int n);
        repeat (n) pkt.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    function automatic logic [7:0] pick_blank(input int kinds);
        case ($urandom_range(kinds - 1))
            0:       return CH_SP;
            1:       return CH_HT;
            2:       return CH_CR;
            3:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic put_length_line();
        int n;
        repeat ($urandom_range(2)) pkt.push_back(pick_blank(2));
        put_str("Content-Length");
        repeat ($urandom_range(2)) pkt.push_back(pick_blank(3));
        pkt.push_back(CH_COLON);
        repeat ($urandom_range(2)) pkt.push_back(pick_blank(5));
        n = int'($urandom_range(40));
        case ($urandom_range(11))
            0, 1, 2, 3, 4: begin
                put_str($sformatf("%0d", n));
                gen_len_hint = n;
            end
            5: begin
                put_str($sformatf("00%0d", n));
                gen_len_hint = n;
            end
            6: begin
                put_str($sformatf("-%0d", n + 1));
                gen_len_hint = -1;
            end
            7: begin
                put_str("-0");
                gen_len_hint = 0;
            end
            8: begin
                put_str($sformatf("+%0d", n));
                gen_len_hint = n;
            end
            9: begin
                if ($urandom_range(1)) begin
                    pkt.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                end
                gen_len_hint = 0;
            end
            10: begin
                repeat ($urandom_range(10, 20)) begin
                    pkt.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                end
                gen_len_hint = -1;
            end
            default: begin
                put_str($urandom_range(1) ? "4294967295" : "4294967296");
                gen_len_hint = -1;
            end
        endcase
        if ($urandom_range(9) < 3) put_str(" ;x");
        put_str("\r\n");
    endtask

    task automatic put_other_line();
        case ($urandom_range(5))
            0:       put_str("Host");
            1:       put_str("content-length");
            2:       put_str("Content-Lengths");
            3:       put_str("Content-Lengt");
            4:       put_str("Accept");
            default: put_str(" X-Content-Length");
        endcase
        pkt.push_back(CH_COLON);
        put_text($urandom_range(0, 8));
        put_str("\r\n");
    endtask

    task automatic build_request(input bit truncate);
        int body_len;
        int cut;
        gen_len_hint = 0;
        put_text($urandom_range(1, 12));
        put_str("\r\n");
        repeat ($urandom_range(3)) begin
            if ($urandom_range(1)) put_length_line();
            else put_other_line();
        end
        put_str("\r\n");
        if (gen_len_hint >= 0) body_len = gen_len_hint + int'($urandom_range(4)) - 2;
        else body_len = int'($urandom_range(6));
        if (body_len < 0) body_len = 0;
        repeat (body_len) pkt.push_back(8'($urandom_range(255)));
        if (truncate) begin
            cut = int'($urandom_range(1, pkt.size()));
            while (pkt.size() > cut) pkt.delete(pkt.size() - 1);
        end
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(7))
                0:       pkt.push_back(CH_CR);
                1:       pkt.push_back(CH_LF);
                2:       pkt.push_back(CH_COLON);
                default: pkt.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    // tests
    task automatic test_no_terminator();
        pkt.push_back(8'hFF);
        send_pkt();
        pkt.push_back(8'h00);
        send_pkt();
        send_str("AB\r\n\r");
        wait_drain();
    endtask

    task automatic test_bare_terminator();
        send_str("\r\n\r\n");
        send_str("\r\r\n\r\n");
        wait_drain();
    endtask

    task automatic test_body_count();
        send_str("G\r\nContent-Length:3\r\n\r\nabc");
        send_str("G\r\nContent-Length:3\r\n\r\nab");
        send_str("G\r\n\r\nxyz");
        wait_drain();
    endtask

    task automatic test_overlong_value();
        send_str("G\r\nContent-Length:99999999999\r\n\r\nx");
        send_str("G\r\nContent-Length:4294967295\r\n\r\nx");
        send_str("G\r\nContent-Length:4294967296\r\n\r\nx");
        wait_drain();
    endtask

    task automatic test_value_signs();
        send_str("G\r\nContent-Length:-5\r\n\r\n");
        send_str("G\r\nContent-Length:-0\r\n\r\n");
        send_str("G\r\nContent-Length:+2\r\n\r\nab");
        send_str("G\r\nContent-Length:-\r\n\r\n");
        put_str("G\r\nContent-Length:");
        pkt.push_back(CH_VT);
        pkt.push_back(CH_FF);
        put_str("\t\r1x\r\n\r\nz");
        send_pkt();
        wait_drain();
    endtask

    task automatic test_last_line_wins();
        send_str("G\r\nContent-Length:5\r\nContent-Length:2\r\n\r\nab");
        send_str("G\r\nContent-Length:7\r\nContent-Length:\r\n\r\n");
        wait_drain();
    endtask

    task automatic test_key_matching();
        send_str("G\r\n \tContent-Length \t\r: 2\r\n\r\nab");
        send_str("G\r\ncontent-length:2\r\n\r\n");
        send_str("Content-Length:9\r\nContent-Lengt:2\r\n\r\n");
        send_str("G\r\nContent-Length 2\r\nX-Content-Length:3\r\n\r\n");
        wait_drain();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int nbytes);
        int phase_bytes;
        int sel;
        phase_bytes = 0;
        idle_pct    = idle;
        stall_pct   = stall;
        while (phase_bytes < nbytes) begin
            sel = int'($urandom_range(99));
            if (sel < 70) build_request(1'b0);
            else if (sel < 85) build_request(1'b1);
            else build_noise();
            phase_bytes += pkt.size();
            send_pkt();
        end
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_len  = 300;
        ->hold_go;
        repeat (40) begin
            pkt.push_back(8'($urandom_range(255)));
            send_pkt();
        end
        build_request(1'b0);
        send_pkt();
        wait_drain();
    endtask

    task automatic test_sender_pause();
        idle_pct  = 36;
        stall_pct = 36;
        repeat (3) begin
            build_request(1'b0);
            send_pkt();
            wait_drain();
        end
    endtask

    initial begin
        clear_framing();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_data_byte     <= 8'h00;
        i_end_of_buffer <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_terminator();
        test_bare_terminator();
        test_body_count();
        test_overlong_value();
        test_value_signs();
        test_last_line_wins();
        test_key_matching();
        test_random_traffic(0, 0, 260);
        test_random_traffic(66, 0, 260);
        test_random_traffic(0, 66, 260);
        test_random_traffic(36, 36, 260);
        test_output_backpressure();
        test_sender_pause();

        repeat (10) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            report($sformatf("%0d results never arrived", verdict_q.size()));
        end
        $display("Sent %0d buffers (%0d bytes), checked %0d results, %0d mismatches.",
                 buffers_sent, bytes_sent, results_seen, err_count);
        $display("Covered framing corner cases plus random traffic with gaps, stalls %s",
                 "and a long hold-off.");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/hrcc_pkg.sv
src/hrcc_line_parser.sv
src/http_request_completeness_check_unit.sv
bench/tb_http_request_completeness_check_unit.sv
